// ===== rtl/per_object_hysteresis_table_top_assert.svh =====
// Assertion macros used by the hysteresis table top level
`ifndef PER_OBJECT_HYSTERESIS_TABLE_TOP_ASSERT_SVH
`define PER_OBJECT_HYSTERESIS_TABLE_TOP_ASSERT_SVH
// implication checked every clock edge outside reset
`define POHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define POHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/poht_pkg.sv =====
// Types and constants of the hysteresis table
`default_nettype none
package poht_pkg;
	localparam logic [1:0] LVL_LOWER  = 2'd0;
	localparam logic [1:0] LVL_HIGHER = 2'd1;
	localparam logic [1:0] LVL_UNDET  = 2'd2;
	localparam logic [0:0] CMD_QUERY  = 1'b0;
	localparam logic [0:0] CMD_SET    = 1'b1;
	localparam logic [1:0] REG_ANCHOR = 2'd0;
	localparam logic [1:0] REG_LOWER  = 2'd1;
	localparam logic [1:0] REG_UPPER  = 2'd2;

	typedef struct packed {
		logic [0:0]         cmd;
		logic [31:0]        obj_id;
		logic signed [31:0] value_in;
		logic signed [31:0] position;
		logic [1:0]         level_in;
		logic [31:0]        frame_seq;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               hit;
		logic [1:0]         level_out;
		logic [6:0]         evicted;
		logic               dropped;
	} rsp_t;
endpackage
`default_nettype wire

// ===== rtl/poht_if.sv =====
// Valid/ready channel interface
`default_nettype none
interface poht_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/poht_ram.sv =====
// Generic single-port RAM with registered read
`default_nettype none
module poht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/per_object_hysteresis_table_top.sv =====
// Top level of the per-object hysteresis table
// Usage:
//   req (sink) carries cmd, obj_id, value_in, position, level_in, frame_seq.
//   rsp (source) carries value_out, hit, level_out, evicted, dropped.
//   cfg_we/cfg_idx/cfg_data write anchor (0), lower_offset (1), upper_offset (2)
//   while the block is idle.
// Each request walks the table through one shared RAM port, one slot a cycle:
//   a lookup pass, then on a query miss with the table at least half full a
//   stale pass and, when still full, a farthest pass that ends with the
//   removal, then a free-slot search. A hit re-reads and updates its slot; a
//   set miss goes to the free-slot search, or is dropped when the table is
//   full. One request is in flight at a time.
// The result sits in an output register; a new request is taken the cycle
//   after the previous result has been handed off. A stalled receiver holds
//   the result.
// Reset clears all valid bits and the fill count at once (valid bits live in
//   flip-flops); entry contents need no clearing.
`default_nettype none
module per_object_hysteresis_table_top #(
	parameter int TABLE_ENTRIES       = 64,
	parameter int LOW_FILL_STALE_AGE  = 5,
	parameter int HIGH_FILL_STALE_AGE = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	poht_if.sink       req,
	poht_if.source     rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [31:0] cfg_data
);
	import poht_pkg::*;
	`include "per_object_hysteresis_table_top_assert.svh"

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = 32 + 2 + 32 + 32;
	localparam logic [CW-1:0] HALF  = CW'(TABLE_ENTRIES / 2);
	localparam logic [CW-1:0] TQ    = CW'(3 * TABLE_ENTRIES / 4);
	localparam logic [CW-1:0] FULL  = CW'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST  = AW'(TABLE_ENTRIES - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOK = 4'd1;
	localparam logic [3:0] S_UPD  = 4'd2;
	localparam logic [3:0] S_STALE = 4'd3;
	localparam logic [3:0] S_FAR  = 4'd4;
	localparam logic [3:0] S_INS  = 4'd5;
	localparam logic [3:0] S_OUT  = 4'd6;
	localparam logic [3:0] S_HRD  = 4'd7;

	logic [3:0] state_q;
	logic signed [31:0] anchor_q, lo_off_q, up_off_q;
	req_t r_q;
	rsp_t o_q;
	logic out_v_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic          rd_v_q;
	logic          tail_q;
	logic [AW-1:0] rd_idx_q;
	logic          found_q;
	logic [AW-1:0] slot_q;
	logic          far_v_q;
	logic [AW-1:0] far_q;
	logic signed [31:0] farpos_q;
	logic [6:0] rem_q;
	logic [31:0] age_lim_q;

	// ram fields: id, level, frame, position
	logic          we;
	logic [AW-1:0] addr;
	logic [RW-1:0] wdata, rdata;
	logic [31:0]   rd_id, rd_frame;
	logic [1:0]    rd_lvl;
	logic signed [31:0] rd_pos;

	poht_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);
	assign {rd_id, rd_lvl, rd_frame, rd_pos} = rdata;

	// limits and pushed values
	logic signed [32:0] anc33, lo33, hi33, val33;
	logic signed [31:0] t_hi, t_lo;
	logic [1:0] lvl_set, new_lvl;
	logic signed [31:0] res;
	always_comb begin
		anc33 = 33'(anchor_q);
		val33 = 33'(r_q.value_in);
		lo33 = anc33 + 33'(lo_off_q);
		hi33 = anc33 + 33'(up_off_q);
		if (lo33 > anc33) lo33 = anc33;
		if (hi33 < anc33) hi33 = anc33;
		t_hi = (anchor_q == 32'sh7fffffff) ? anchor_q : anchor_q + 32'sd1;
		t_lo = (anchor_q == 32'sh80000000) ? anchor_q : anchor_q - 32'sd1;
		lvl_set = (r_q.level_in == 2'd3) ? LVL_UNDET : r_q.level_in;
		new_lvl = rd_lvl;
		if (rd_frame != r_q.frame_seq) begin
			if (val33 >= hi33) new_lvl = LVL_HIGHER;
			else if (val33 <= lo33) new_lvl = LVL_LOWER;
		end
		unique case (new_lvl)
			LVL_HIGHER: res = (r_q.value_in > t_hi) ? r_q.value_in : t_hi;
			LVL_LOWER:  res = (r_q.value_in < t_lo) ? r_q.value_in : t_lo;
			default:    res = r_q.value_in;
		endcase
	end

	logic look_match, stale_hit;
	assign look_match = rd_v_q && valid_q[rd_idx_q] && rd_id == r_q.obj_id;
	assign stale_hit = rd_v_q && valid_q[rd_idx_q]
		&& (r_q.frame_seq - rd_frame) > age_lim_q;

	// first free slot, found by scanning valid bits one per cycle
	logic miss_lvl_hi;
	assign miss_lvl_hi = r_q.value_in > anchor_q;

	always_comb begin
		we = 1'b0;
		addr = idx_q;
		wdata = rdata;
		if (state_q == S_HRD) begin
			addr = slot_q;
		end else if (state_q == S_UPD) begin
			addr = slot_q;
			we = 1'b1;
			if (r_q.cmd == CMD_SET)
				wdata = {rd_id, lvl_set, rd_frame, rd_pos};
			else if (rd_frame != r_q.frame_seq)
				wdata = {rd_id, new_lvl, r_q.frame_seq, r_q.position};
		end else if (state_q == S_INS && !valid_q[idx_q]) begin
			we = 1'b1;
			if (r_q.cmd == CMD_SET)
				wdata = {r_q.obj_id, lvl_set, r_q.frame_seq, 32'sd0};
			else
				wdata = {r_q.obj_id, miss_lvl_hi ? LVL_HIGHER : LVL_LOWER,
					r_q.frame_seq, r_q.position};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= '0;
			lo_off_q <= '0;
			up_off_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ANCHOR: anchor_q <= cfg_data;
				REG_LOWER:  lo_off_q <= cfg_data;
				REG_UPPER:  up_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			valid_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			tail_q <= 1'b0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
			far_v_q <= 1'b0;
			r_q <= '0;
			o_q <= '0;
			slot_q <= '0;
			far_q <= '0;
			farpos_q <= '0;
			rem_q <= '0;
			age_lim_q <= '0;
		end else begin
			rd_idx_q <= idx_q;
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q <= req.data;
						idx_q <= '0;
						found_q <= 1'b0;
						rem_q <= '0;
						rd_v_q <= 1'b1;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (look_match && !found_q) begin
						found_q <= 1'b1;
						slot_q <= rd_idx_q;
					end
					if (tail_q) begin
						// last slot checked; decide next cycle
						tail_q <= 1'b0;
						rd_v_q <= 1'b0;
					end else if (rd_v_q && idx_q != LAST) begin
						idx_q <= idx_q + AW'(1);
						rd_v_q <= 1'b1;
					end else if (rd_v_q) begin
						// hold index at last slot while the final read lands
						tail_q <= 1'b1;
						rd_v_q <= 1'b1;
					end else begin
						idx_q <= '0;
						if (found_q) begin
							state_q <= S_HRD;
						end else if (r_q.cmd == CMD_SET) begin
							if (count_q < FULL) state_q <= S_INS;
							else begin
								o_q <= '{value_out: '0, hit: 1'b0, level_out: LVL_UNDET,
									evicted: '0, dropped: 1'b1};
								state_q <= S_OUT;
							end
						end else if (count_q >= HALF) begin
							age_lim_q <= (count_q < TQ) ? 32'(LOW_FILL_STALE_AGE)
								: 32'(HIGH_FILL_STALE_AGE);
							rd_v_q <= 1'b1;
							state_q <= S_STALE;
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_HRD: begin
					// re-read the hit slot
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (r_q.cmd == CMD_SET)
						o_q <= '{value_out: '0, hit: 1'b1, level_out: lvl_set,
							evicted: '0, dropped: 1'b0};
					else
						o_q <= '{value_out: res, hit: 1'b1, level_out: new_lvl,
							evicted: '0, dropped: 1'b0};
					state_q <= S_OUT;
				end
				S_STALE: begin
					if (stale_hit) begin
						valid_q[rd_idx_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						rem_q <= rem_q + 7'd1;
					end
					if (tail_q) begin
						tail_q <= 1'b0;
						rd_v_q <= 1'b0;
					end else if (rd_v_q && idx_q != LAST) begin
						idx_q <= idx_q + AW'(1);
						rd_v_q <= 1'b1;
					end else if (rd_v_q) begin
						tail_q <= 1'b1;
						rd_v_q <= 1'b1;
					end else begin
						idx_q <= '0;
						if (count_q >= FULL) begin
							far_v_q <= 1'b0;
							rd_v_q <= 1'b1;
							state_q <= S_FAR;
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_FAR: begin
					// of equal positions keep the lowest slot
					if (rd_v_q && valid_q[rd_idx_q] && (!far_v_q || rd_pos > farpos_q
						|| (rd_pos == farpos_q && rd_idx_q < far_q))) begin
						far_v_q <= 1'b1;
						far_q <= rd_idx_q;
						farpos_q <= rd_pos;
					end
					if (tail_q) begin
						tail_q <= 1'b0;
						rd_v_q <= 1'b0;
					end else if (rd_v_q && idx_q != LAST) begin
						idx_q <= idx_q + AW'(1);
						rd_v_q <= 1'b1;
					end else if (rd_v_q) begin
						tail_q <= 1'b1;
						rd_v_q <= 1'b1;
					end else begin
						idx_q <= '0;
						if (far_v_q) begin
							valid_q[far_q] <= 1'b0;
							count_q <= count_q - CW'(1);
							rem_q <= rem_q + 7'd1;
						end
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						count_q <= count_q + CW'(1);
						if (r_q.cmd == CMD_SET)
							o_q <= '{value_out: '0, hit: 1'b0, level_out: lvl_set,
								evicted: '0, dropped: 1'b0};
						else
							o_q <= '{value_out: r_q.value_in, hit: 1'b0,
								level_out: miss_lvl_hi ? LVL_HIGHER : LVL_LOWER,
								evicted: rem_q, dropped: 1'b0};
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`POHT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL, "fill count overflow")
	`POHT_ASSERT_IMP(a_ins_room, clk, arst_n, state_q == S_INS, count_q < FULL,
		"insert with full table")
	`POHT_ASSERT_NEXT(a_out_hold, clk, arst_n, rsp.valid && !rsp.ready,
		rsp.valid && $stable(o_q), "result lost under stall")
	`POHT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !req.ready,
		"request taken while busy")
endmodule
`default_nettype wire

// ===== sim/poht_level_checker.sv =====
// Checker for the hysteresis table: predicts each response and compares it
`default_nettype none
module poht_level_checker
	import poht_pkg::*;
#(
	parameter int TABLE_ENTRIES       = 64,
	parameter int LOW_FILL_STALE_AGE  = 5,
	parameter int HIGH_FILL_STALE_AGE = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_ready,
	input  wire req_t        req_data,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_ready,
	input  wire rsp_t        rsp_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               pending
);
	logic signed [31:0] anchor_q, lower_q, upper_q;
	bit                 tv [TABLE_ENTRIES];
	logic [31:0]        tid [TABLE_ENTRIES];
	logic [1:0]         tlvl [TABLE_ENTRIES];
	logic [31:0]        tfrm [TABLE_ENTRIES];
	logic signed [31:0] tpos [TABLE_ENTRIES];
	int                 fill;
	rsp_t               expected_rsps [$];

	assign pending = expected_rsps.size();

	function automatic int find_entry(logic [31:0] id);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tv[i] && tid[i] == id) return i;
		return -1;
	endfunction

	function automatic void store_entry(logic [31:0] id, logic [1:0] l, logic [31:0] f,
			logic signed [31:0] p);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!tv[i]) begin
				tv[i] = 1; tid[i] = id; tlvl[i] = l; tfrm[i] = f; tpos[i] = p;
				fill++;
				return;
			end
	endfunction

	function automatic int evict_stale(logic [31:0] now);
		int removed, far;
		logic [31:0] age_lim, age;
		removed = 0;
		far = -1;
		if (fill < TABLE_ENTRIES / 2) return 0;
		age_lim = (fill < 3 * TABLE_ENTRIES / 4) ? LOW_FILL_STALE_AGE : HIGH_FILL_STALE_AGE;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			age = now - tfrm[i];
			if (tv[i] && age > age_lim) begin
				tv[i] = 0; fill--; removed++;
			end
		end
		if (fill >= TABLE_ENTRIES) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (tv[i] && (far < 0 || tpos[i] > tpos[far])) far = i;
			if (far >= 0) begin
				tv[far] = 0; fill--; removed++;
			end
		end
		return removed;
	endfunction

	function automatic rsp_t predict_level(req_t r);
		rsp_t o;
		longint anc, lo, hi, val, t, res;
		logic [1:0] lin;
		int s;
		anc = anchor_q;
		lo = anc + longint'(lower_q);
		hi = anc + longint'(upper_q);
		val = r.value_in;
		res = val;
		if (lo > anc) lo = anc;
		if (hi < anc) hi = anc;
		lin = (r.level_in == 2'd3) ? LVL_UNDET : r.level_in;
		o = '0;
		o.level_out = LVL_UNDET;
		s = find_entry(r.obj_id);
		if (r.cmd == CMD_SET) begin
			res = 0;
			if (s >= 0) begin
				o.hit = 1; tlvl[s] = lin; o.level_out = lin;
			end else if (fill < TABLE_ENTRIES) begin
				store_entry(r.obj_id, lin, r.frame_seq, 0);
				o.level_out = lin;
			end else
				o.dropped = 1;
		end else if (s >= 0) begin
			o.hit = 1;
			if (tfrm[s] != r.frame_seq) begin
				tpos[s] = r.position;
				tfrm[s] = r.frame_seq;
				if (val >= hi) tlvl[s] = LVL_HIGHER;
				else if (val <= lo) tlvl[s] = LVL_LOWER;
			end
			o.level_out = tlvl[s];
			if (tlvl[s] == LVL_HIGHER) begin
				t = anc + 1;
				if (t > 64'sd2147483647) t = 64'sd2147483647;
				res = (val > t) ? val : t;
			end else if (tlvl[s] == LVL_LOWER) begin
				t = anc - 1;
				if (t < -64'sd2147483648) t = -64'sd2147483648;
				res = (val < t) ? val : t;
			end
		end else begin
			o.evicted = 7'(evict_stale(r.frame_seq));
			o.level_out = (val > anc) ? LVL_HIGHER : LVL_LOWER;
			store_entry(r.obj_id, o.level_out, r.frame_seq, r.position);
		end
		o.value_out = 32'(res);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			anchor_q = 0; lower_q = 0; upper_q = 0; fill = 0; errors = 0;
			for (int i = 0; i < TABLE_ENTRIES; i++) tv[i] = 0;
			expected_rsps.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: response with nothing expected, actual %p", $time, rsp_data);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (e !== rsp_data) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, e, rsp_data);
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsps = {expected_rsps, predict_level(req_data)};
			if (cfg_we) begin
				case (cfg_idx)
					REG_ANCHOR: anchor_q = cfg_data;
					REG_LOWER:  lower_q = cfg_data;
					REG_UPPER:  upper_q = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== sim/tb_per_object_hysteresis_table_top.sv =====
// Testbench top: drives requests and configuration, gives the verdict
`default_nettype none
module tb_per_object_hysteresis_table_top;
	import poht_pkg::*;
	localparam int N = 64;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	logic        calm = 0;
	int          errors, pending;
	logic [31:0] frame_now = 100;
	logic [31:0] id_pool [16];

	poht_if #(.T(req_t)) req ();
	poht_if #(.T(rsp_t)) rsp ();

	per_object_hysteresis_table_top dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	poht_level_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
	end

	always #1 clk = ~clk;

	// receiver stalls in short bursts
	always @(posedge clk) begin
		if (!calm && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rsp.ready <= 1;
	end

	task automatic send_request(logic cmd, logic [31:0] id, logic [31:0] v, logic [31:0] p,
			logic [1:0] l, logic [31:0] f);
		req_t r;
		if (!calm && $urandom_range(0, 4) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		r.cmd = cmd; r.obj_id = id; r.value_in = v; r.position = p;
		r.level_in = l; r.frame_seq = f;
		req.valid <= 1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain_and_write(logic [1:0] idx, logic [31:0] d);
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4 * N + 16) @(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] wide_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 6) - 3;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] id;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (id_pool[i]) id_pool[i] = $urandom;
		id_pool[0] = 32'hffffffff;
		id_pool[1] = 32'h0;
		// directed: extremes, both commands, same frame, set on hit and miss
		send_request(CMD_QUERY, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 2'd3, 32'hffffffff);
		send_request(CMD_QUERY, 32'h0, 32'h80000000, 32'h80000000, 2'd0, 32'h0);
		send_request(CMD_QUERY, 32'hffffffff, 32'h80000000, 32'h0, 2'd0, 32'h0);
		send_request(CMD_QUERY, 32'hffffffff, 32'h7fffffff, 32'h5, 2'd0, 32'h0);
		send_request(CMD_SET, 32'h0, 32'h1, 32'h1, 2'd3, 32'h1);
		send_request(CMD_QUERY, 32'h0, 32'h12345, 32'h0, 2'd0, 32'h2);
		send_request(CMD_SET, 32'h55, 32'h0, 32'h0, 2'd1, 32'h2);
		send_request(CMD_QUERY, 32'h55, 32'hffff0000, 32'h0, 2'd0, 32'h2);
		send_request(CMD_SET, 32'h55, 32'h0, 32'h0, 2'd0, 32'h3);
		send_request(CMD_QUERY, 32'h55, 32'h0, 32'h0, 2'd2, 32'h3);
		// extreme register settings
		drain_and_write(REG_ANCHOR, 32'h7fffffff);
		drain_and_write(REG_LOWER, 32'h80000000);
		drain_and_write(REG_UPPER, 32'h7fffffff);
		send_request(CMD_QUERY, 32'hffffffff, 32'h7fffffff, 32'h0, 2'd0, 32'h9);
		send_request(CMD_QUERY, 32'h0, 32'h80000000, 32'h0, 2'd0, 32'h9);
		drain_and_write(REG_ANCHOR, 32'h80000000);
		drain_and_write(REG_UPPER, 32'h80000000);
		drain_and_write(REG_LOWER, 32'h7fffffff);
		send_request(CMD_QUERY, 32'hffffffff, 32'h80000000, 32'h0, 2'd0, 32'ha);
		send_request(CMD_QUERY, 32'h0, 32'h7fffffff, 32'h0, 2'd0, 32'ha);
		drain_and_write(REG_ANCHOR, 32'h0);
		drain_and_write(REG_LOWER, 32'hfffe0000);
		drain_and_write(REG_UPPER, 32'h00020000);
		// random: frames advance, many ids fill the table to drive eviction
		for (k = 0; k < 400; k++) begin
			if (k == 150) begin
				drain_and_write(REG_ANCHOR, $urandom_range(0, 3) << 16);
				drain_and_write(REG_LOWER, -($urandom_range(0, 4) << 16));
				drain_and_write(REG_UPPER, $urandom_range(0, 4) << 16);
			end
			if (k == 300) begin
				// hold off until the table is quiet
				req.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (k == 330) calm = 1;
			if ($urandom_range(0, 2) == 0) frame_now = frame_now + $urandom_range(1, 3);
			if ($urandom_range(0, 39) == 0) frame_now = $urandom;
			if (k < 200 && $urandom_range(0, 1) == 0) id = $urandom;
			else if ($urandom_range(0, 3) == 0) id = id_pool[$urandom_range(0, 15)];
			else id = $urandom_range(0, 90);
			send_request($urandom_range(0, 7) == 0 ? CMD_SET : CMD_QUERY, id,
				($urandom_range(0, 1) ? wide_value() : ($urandom_range(0, 8) << 16) - 32'h40000),
				wide_value(), 2'($urandom_range(0, 3)), frame_now);
		end
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4 * N + 16) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/poht_pkg.sv
rtl/poht_if.sv
rtl/poht_ram.sv
rtl/per_object_hysteresis_table_top.sv
sim/poht_level_checker.sv
sim/tb_per_object_hysteresis_table_top.sv
